// ===== sv/glbp_pkg.sv =====
package glbp_pkg;

  localparam int BYTE_BITS    = 8;
  localparam int BYTE_W       = 8;
  localparam int BPP_W        = 4;
  localparam int FREE_W       = 4;

  // output queue: up to two words are pushed per pixel
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);
  localparam int PUSH_W       = 2;

  localparam logic [BPP_W-1:0]  BPP_RESET  = BPP_W'(BYTE_BITS);
  localparam logic [FREE_W-1:0] FREE_RESET = FREE_W'(BYTE_BITS);

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_byte;
  } out_word_t;

  typedef struct packed {
    logic [PUSH_W-1:0] num;
    out_word_t         w0;
    out_word_t         w1;
  } pack_res_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room;
  } fifo_stat_t;

endpackage

// ===== sv/gray_level_bit_packer.sv =====
// Gray level bit packer.
// Input channel (in_valid/in_ready): one 8-bit gray pixel per word, with
// in_last_pixel marking the final pixel of an image. Each pixel is cut to
// cfg_wr_data bits (0 acts as 1, above 8 acts as 8) by dropping low bits; a
// nonzero pixel never packs as zero. Codes are packed MSB-first into bytes.
// Output channel (out_valid/out_ready): one packed byte per word; the final
// byte of an image carries out_last_byte, a partial byte is flushed with
// zero low bits. A pixel yields zero, one or two words.
// Configuration: pulse cfg_wr_en with the width; write only while idle.
// Path: an accepted pixel is held in the input register; the pack step then
// queues its words once the output queue has room for two, and out_valid is set from the registered queue count.
// Throughput: one pixel per cycle while the output queue has room; the
// output port drains one word per cycle while out_ready is high, and only
// the last pixel of an image can produce two words.
// Reset (rst_n, synchronous): empties the input register and the four-entry
// output queue, clears the partial byte and sets the width to 8.
// Receiver stall: words wait in the output queue; once it has fewer than two
// free entries the input register holds and in_ready drops.
module gray_level_bit_packer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [glbp_pkg::BYTE_W-1:0]  in_pixel,
  input  logic                         in_last_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [glbp_pkg::BYTE_W-1:0]  out_packed_byte,
  output logic                         out_last_byte,
  input  logic                         cfg_wr_en,
  input  logic [glbp_pkg::BPP_W-1:0]   cfg_wr_data
);
  import glbp_pkg::*;

  logic [BPP_W-1:0]  bpp_r, bpp_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_pixel_r;
  logic              s1_last_r;
  logic              fire;
  logic              in_fire;
  pack_res_t         res;
  out_word_t         head;
  fifo_stat_t        fstat;

  // advance the held pixel only when the queue can take two words
  assign fire     = s1_valid_r && fstat.room;
  assign in_ready = !s1_valid_r || fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    bpp_nxt      = cfg_wr_en ? cfg_wr_data : bpp_r;
    s1_valid_nxt = in_fire || (s1_valid_r && !fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r      <= BPP_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      bpp_r      <= bpp_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // input register payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_pixel;
      s1_last_r  <= in_last_pixel;
    end
  end

  glbp_pack_unit u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .bpp        (bpp_r),
    .pixel      (s1_pixel_r),
    .last_pixel (s1_last_r),
    .res        (res)
  );

  glbp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .push_en   (fire),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (head),
    .stat      (fstat)
  );

  assign out_packed_byte = head.packed_byte;
  assign out_last_byte   = head.last_byte;

`ifndef SYNTH
  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fstat.count <= CNT_W'(FIFO_DEPTH))
    else $error("output queue over depth");

  // a last pixel always pushes at least one word
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_last_r |-> res.num != '0)
    else $error("last pixel produced no word");

  // a second word is only ever the marked flush byte
  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.num == PUSH_W'(2) |-> s1_last_r && res.w1.last_byte)
    else $error("two words pushed without last pixel");

  // reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_valid_r)
    else $error("output not empty after reset");
`endif

endmodule

// ===== sv/glbp_pack_unit.sv =====
module glbp_pack_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [glbp_pkg::BPP_W-1:0]    bpp,
  input  logic [glbp_pkg::BYTE_W-1:0]   pixel,
  input  logic                          last_pixel,
  output glbp_pkg::pack_res_t           res
);
  import glbp_pkg::*;

  logic [BYTE_W-1:0] partial_r, partial_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;

  logic [FREE_W-1:0] width;
  logic [FREE_W-1:0] nf;
  logic [FREE_W-1:0] over;
  logic [BYTE_W-1:0] code;
  logic [BYTE_W-1:0] acc;
  logic [BYTE_W-1:0] byte_a;
  logic              emit_a;
  logic              flush;
  logic [2*BYTE_W-1:0] code_sh;

  always_comb begin
    // clamp width to 1..8
    if (bpp == '0) begin
      width = FREE_W'(1);
    end else if (bpp > BPP_W'(BYTE_BITS)) begin
      width = FREE_W'(BYTE_BITS);
    end else begin
      width = bpp;
    end

    // reduce pixel; keep nonzero pixels nonzero
    code = pixel >> (FREE_W'(BYTE_BITS) - width);
    if (pixel != '0 && code == '0) begin
      code = BYTE_W'(1);
    end

    over    = '0;
    emit_a  = 1'b0;
    byte_a  = '0;
    code_sh = '0;
    if (width <= free_r) begin
      nf      = free_r - width;
      code_sh = {{BYTE_W{1'b0}}, code} << nf;
      acc     = partial_r | code_sh[BYTE_W-1:0];
      if (nf == '0) begin
        emit_a = 1'b1;
        byte_a = acc;
        acc    = '0;
        nf     = FREE_W'(BYTE_BITS);
      end
    end else begin
      // code straddles: high part closes this byte, low part opens the next
      over    = width - free_r;
      emit_a  = 1'b1;
      byte_a  = partial_r | (code >> over);
      nf      = FREE_W'(BYTE_BITS) - over;
      code_sh = {{BYTE_W{1'b0}}, code} << nf;
      acc     = code_sh[BYTE_W-1:0];
    end

    flush = last_pixel && (nf != FREE_W'(BYTE_BITS));

    res = '0;
    if (emit_a) begin
      res.w0.packed_byte = byte_a;
      res.w0.last_byte   = last_pixel && !flush;
      res.w1.packed_byte = acc;
      res.w1.last_byte   = 1'b1;
      res.num            = flush ? PUSH_W'(2) : PUSH_W'(1);
    end else if (flush) begin
      res.w0.packed_byte = acc;
      res.w0.last_byte   = 1'b1;
      res.num            = PUSH_W'(1);
    end

    partial_nxt = partial_r;
    free_nxt    = free_r;
    if (fire) begin
      if (last_pixel) begin
        partial_nxt = '0;
        free_nxt    = FREE_RESET;
      end else begin
        partial_nxt = acc;
        free_nxt    = nf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      free_r    <= FREE_RESET;
    end else begin
      partial_r <= partial_nxt;
      free_r    <= free_nxt;
    end
  end

endmodule

// ===== sv/glbp_out_fifo.sv =====
module glbp_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  glbp_pkg::pack_res_t          push,
  input  logic                         push_en,
  input  logic                         out_ready,
  output logic                         out_valid,
  output glbp_pkg::out_word_t          out_word,
  output glbp_pkg::fifo_stat_t         stat
);
  import glbp_pkg::*;

  out_word_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PUSH_W-1:0] num;
  logic              pop;
  logic [PTR_W-1:0]  wr_ptr_p1;

  assign num       = push_en ? push.num : '0;
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_word  = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  assign stat.count = count_r;
  assign stat.room  = (count_r <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(num);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(num) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (num != '0) begin
      mem_r[wr_ptr_r] <= push.w0;
    end
    if (num == PUSH_W'(2)) begin
      mem_r[wr_ptr_p1] <= push.w1;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import glbp_pkg::*;

  // Kinds of row in the directed table: a width write or one pixel word
  typedef enum logic {
    ROW_WIDTH,
    ROW_PIXEL
  } row_kind_t;

  // One directed step. Pixel rows with typed set carry their byte words
  // inline; all other pixel rows are checked against pack_pixel.
  typedef struct packed {
    row_kind_t         kind;
    logic [BYTE_W-1:0] value;
    logic              lst;
    logic              typed;
    logic [1:0]        cnt;
    out_word_t         b0;
    out_word_t         b1;
  } row_t;

  localparam out_word_t NO_WORD    = '0;
  localparam int        DIR_ROWS   = 25;
  localparam int        RAND_ITEMS = 1200;
  localparam int        CALM_AFTER = 1050;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] in_pixel;
  logic              in_last_pixel;
  logic              out_valid;
  logic              out_ready;
  logic [BYTE_W-1:0] out_packed_byte;
  logic              out_last_byte;
  logic              cfg_wr_en;
  logic [BPP_W-1:0]  cfg_wr_data;

  // Mirror of the packer: width register, byte under fill, free bit slots
  logic [BPP_W-1:0] bpp_reg   = BPP_RESET;
  logic [7:0]       fill_byte = '0;
  int               free_bits = BYTE_BITS;

  out_word_t pending_bytes[$];
  int        bad_words   = 0;
  int        pixels_sent = 0;
  bit        idle_on     = 1'b1;
  int        stall_left  = 0;

  // Directed table: extremes, width clamping, straddling codes, the
  // nonzero-pixel-raised-to-one rule, flushes and an exact-fill last pixel
  row_t steps [DIR_ROWS] = '{
    '{ROW_PIXEL, 8'hA5, 1'b0, 1'b1, 2'd1, '{8'hA5, 1'b0}, NO_WORD},
    '{ROW_PIXEL, 8'hFF, 1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1}, NO_WORD},
    '{ROW_PIXEL, 8'h00, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b1}, NO_WORD},
    '{ROW_PIXEL, 8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b0}, NO_WORD},
    '{ROW_WIDTH, 8'd1,  1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h01, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h00, 1'b1, 1'b1, 2'd1, '{8'h80, 1'b1}, NO_WORD},
    '{ROW_WIDTH, 8'd0,  1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h80, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h7F, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_WIDTH, 8'd15, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h3C, 1'b0, 1'b1, 2'd1, '{8'h3C, 1'b0}, NO_WORD},
    '{ROW_WIDTH, 8'd3,  1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'hE0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'hFF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h20, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_WIDTH, 8'd5,  1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h07, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h9A, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_WIDTH, 8'd2,  1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'hC0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h40, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h80, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_PIXEL, 8'h01, 1'b1, 1'b1, 2'd1, '{8'hD9, 1'b1}, NO_WORD},
    '{ROW_WIDTH, 8'd8,  1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD}
  };

  gray_level_bit_packer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_last_byte   (out_last_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Pack one pixel into the mirror state; return how many byte words it
  // produces (0..2) in w0/w1, the final one of an image flagged last.
  function automatic int pack_pixel(input logic [BYTE_W-1:0] pix, input logic lst,
                                    output out_word_t w0, output out_word_t w1);
    out_word_t res [2];
    int        wid;
    int        code;
    int        acc;
    int        room;
    int        over;
    int        n;
    res[0] = NO_WORD;
    res[1] = NO_WORD;
    n      = 0;
    // clamp the width: zero acts as one, anything above a byte as a byte
    if (bpp_reg == 0) wid = 1;
    else if (bpp_reg > BYTE_BITS) wid = BYTE_BITS;
    else wid = bpp_reg;
    // drop the low bits; a nonzero pixel never packs as zero
    code = int'(pix) >> (BYTE_BITS - wid);
    if (pix != 0 && code == 0) code = 1;
    acc  = fill_byte;
    room = free_bits;
    if (wid <= room) begin
      room = room - wid;
      acc  = (acc | (code << room)) & 8'hFF;
      if (room == 0) begin
        res[n] = '{packed_byte: 8'(acc), last_byte: 1'b0};
        n++;
        acc  = 0;
        room = BYTE_BITS;
      end
    end else begin
      // code straddles: high part closes this byte, low part opens the next
      over   = wid - room;
      res[n] = '{packed_byte: 8'((acc | (code >> over)) & 8'hFF), last_byte: 1'b0};
      n++;
      room = BYTE_BITS - over;
      acc  = (code << room) & 8'hFF;
    end
    if (lst) begin
      // flush a partial byte; an exactly filled byte is itself the last one
      if (room < BYTE_BITS) begin
        res[n] = '{packed_byte: 8'(acc), last_byte: 1'b0};
        n++;
      end
      res[n-1].last_byte = 1'b1;
      acc  = 0;
      room = BYTE_BITS;
    end
    fill_byte = 8'(acc);
    free_bits = room;
    w0 = res[0];
    w1 = res[1];
    return n;
  endfunction

  // Run one row: a width write waits until the packer is idle, a pixel row
  // presents one word, waits for the handshake and queues its byte words.
  task automatic run_row(input row_t r);
    out_word_t w0;
    out_word_t w1;
    int        n;
    if (r.kind == ROW_WIDTH) begin
      @(negedge clk);
      in_valid = 1'b0;
      // drain every queued byte, then let a byte-less pixel clear the pipe
      while (pending_bytes.size() != 0) @(posedge clk);
      repeat (4) @(negedge clk);
      cfg_wr_en   = 1'b1;
      cfg_wr_data = r.value[BPP_W-1:0];
      @(negedge clk);
      cfg_wr_en = 1'b0;
      bpp_reg   = r.value[BPP_W-1:0];
    end else begin
      @(negedge clk);
      in_valid      = 1'b1;
      in_pixel      = r.value;
      in_last_pixel = r.lst;
      // hold the word until the edge that takes it
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      pixels_sent++;
      n = pack_pixel(r.value, r.lst, w0, w1);
      if (r.typed) begin
        n  = r.cnt;
        w0 = r.b0;
        w1 = r.b1;
      end
      if (n > 0) pending_bytes.push_back(w0);
      if (n > 1) pending_bytes.push_back(w1);
    end
  endtask

  // Receiver: stall in random bursts while idling is on
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Check each accepted byte word against the oldest queued one
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word: byte %02h last %0b", out_packed_byte, out_last_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (want.packed_byte !== out_packed_byte || want.last_byte !== out_last_byte) begin
          bad_words++;
          if (bad_words <= 10)
            $display("word mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                     want.packed_byte, want.last_byte, out_packed_byte, out_last_byte);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random images, drain, verdict
  initial begin
    row_t r;
    int   len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_pixel      = '0;
    in_last_pixel = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (steps[k]) run_row(steps[k]);

    while (pixels_sent < DIR_ROWS + RAND_ITEMS) begin
      // idle in most phases; keep the tail of the run free of idling
      idle_on = (pixels_sent < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      r      = '0;
      r.kind = ROW_WIDTH;
      case ($urandom_range(0, 5))
        0:       r.value = 8'd0;
        1:       r.value = 8'd1;
        2:       r.value = 8'd8;
        3:       r.value = 8'd15;
        default: r.value = 8'($urandom_range(0, 15));
      endcase
      run_row(r);
      len = $urandom_range(8, 60);
      for (int i = 0; i < len; i++) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        r      = '0;
        r.kind = ROW_PIXEL;
        // favor small pixels so narrow widths hit the raise-to-one rule
        r.value = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(0, 255));
        // most images end before the phase; some run across a width change
        r.lst = (i == len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        run_row(r);
      end
    end

    idle_on = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    // watch a few more edges for stray words
    repeat (10) @(posedge clk);
    if (bad_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Bound the run well past the slowest legal one
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/glbp_pkg.sv
sv/glbp_pack_unit.sv
sv/glbp_out_fifo.sv
sv/gray_level_bit_packer.sv
test/tb.sv
